/* sv/afs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants of the frame sequencer
// Register offsets, frame step positions and the length load table.
// ----------------------------------------------------------------------------
package afs_pkg;

	localparam logic [13:0] FOUR_STEP_LEN = 14'd14916;
	localparam logic [14:0] FIVE_STEP_LEN = 15'd18640;
	localparam logic [14:0] STEP_ONE      = 15'd3729;
	localparam logic [14:0] STEP_TWO      = 15'd7458;
	localparam logic [14:0] STEP_THREE    = 15'd11187;
	localparam logic [11:0] PERIOD_MAX    = 12'h7ff;

	localparam logic [4:0] A_VOL0   = 5'h00;
	localparam logic [4:0] A_SWP0   = 5'h01;
	localparam logic [4:0] A_LO0    = 5'h02;
	localparam logic [4:0] A_HI0    = 5'h03;
	localparam logic [4:0] A_VOL1   = 5'h04;
	localparam logic [4:0] A_SWP1   = 5'h05;
	localparam logic [4:0] A_LO1    = 5'h06;
	localparam logic [4:0] A_HI1    = 5'h07;
	localparam logic [4:0] A_TRI    = 5'h08;
	localparam logic [4:0] A_TRILEN = 5'h0b;
	localparam logic [4:0] A_VOL2   = 5'h0c;
	localparam logic [4:0] A_NOILEN = 5'h0f;
	localparam logic [4:0] A_ENABLE = 5'h15;
	localparam logic [4:0] A_FRAME  = 5'h17;

	typedef struct packed {
		logic quarter;
		logic half;
	} frame_evt_t;

	function automatic logic [7:0] len_lookup(input logic [4:0] idx);
		logic [7:0] r;
		case (idx)
			5'd0: r = 8'd10;   5'd1: r = 8'd254; 5'd2: r = 8'd20;  5'd3: r = 8'd2;
			5'd4: r = 8'd40;   5'd5: r = 8'd4;   5'd6: r = 8'd80;  5'd7: r = 8'd6;
			5'd8: r = 8'd160;  5'd9: r = 8'd8;   5'd10: r = 8'd60; 5'd11: r = 8'd10;
			5'd12: r = 8'd14;  5'd13: r = 8'd12; 5'd14: r = 8'd26; 5'd15: r = 8'd14;
			5'd16: r = 8'd12;  5'd17: r = 8'd16; 5'd18: r = 8'd24; 5'd19: r = 8'd18;
			5'd20: r = 8'd48;  5'd21: r = 8'd20; 5'd22: r = 8'd96; 5'd23: r = 8'd22;
			5'd24: r = 8'd192; 5'd25: r = 8'd24; 5'd26: r = 8'd72; 5'd27: r = 8'd26;
			5'd28: r = 8'd16;  5'd29: r = 8'd28; 5'd30: r = 8'd32; 5'd31: r = 8'd30;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	// sweep target, clamped at zero; bit 11 flags overflow past 0x7ff
	function automatic logic [11:0] sweep_target(input logic [10:0] p,
		input logic [7:0] s, input logic ones);
		logic [11:0] d;
		logic [12:0] t;
		d = {1'b0, p >> s[2:0]};
		if (s[3]) begin
			t = {2'b00, p} - {1'b0, d} - {12'd0, ones};
			if (t[12]) t = 13'd0;
		end else begin
			t = {2'b00, p} + {1'b0, d};
		end
		return t[11:0];
	endfunction

endpackage

/* sv/afs_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_timer: frame step counters
// Two wrapping counters, decoded to quarter and half frame events.
// ----------------------------------------------------------------------------
module afs_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic               five,
	output afs_pkg::frame_evt_t evt,
	output logic               wrap4
);
	import afs_pkg::*;

	logic [13:0] cnt4_q;
	logic [14:0] cnt5_q;
	logic [14:0] pos;

	assign pos = five ? cnt5_q : {1'b0, cnt4_q};
	assign evt.quarter = (pos == STEP_ONE) || (pos == STEP_THREE) ||
		(pos == STEP_TWO) || (pos == 15'd0);
	assign evt.half = (pos == STEP_TWO) || (pos == 15'd0);
	assign wrap4 = (cnt4_q == 14'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt4_q <= '0;
			cnt5_q <= '0;
		end else if (tick) begin
			cnt4_q <= (cnt4_q == FOUR_STEP_LEN - 14'd1) ? 14'd0 : cnt4_q + 14'd1;
			cnt5_q <= (cnt5_q == FIVE_STEP_LEN - 15'd1) ? 15'd0 : cnt5_q + 15'd1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) evt.half |-> evt.quarter)
		else $error("half frame without quarter frame");
	assert property (@(posedge clk) disable iff (!arst_n) cnt4_q < FOUR_STEP_LEN)
		else $error("four step counter out of range");
	assert property (@(posedge clk) disable iff (!arst_n) cnt5_q < FIVE_STEP_LEN)
		else $error("five step counter out of range");

endmodule

/* sv/apu_frame_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_frame_sequencer: sound unit frame sequencer
// Ticks and register writes in, one status word out per input word.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with req_type, reg_addr, write_data. A word
// is either one tick of the sound unit or a register write at 0x4000+addr.
// Output channel: out_valid/out_stall carries one status word per input word:
// IRQ flag, frame events of this tick, pulse periods, sweep mutes, envelope
// levels, linear counter and length counter activity.
// All state updates in the cycle the word is taken; the status word appears
// in the output register in the next cycle. One word per cycle is taken,
// limited only by the single output register: the input is stalled only
// while a status word is held and the receiver stalls.
// Reset clears every counter and state register and empties the output register.
// ----------------------------------------------------------------------------
module apu_frame_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [4:0]  reg_addr,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_irq,
	output logic        quarter_frame,
	output logic        half_frame,
	output logic [10:0] pulse1_period,
	output logic [10:0] pulse2_period,
	output logic [1:0]  sweep_mute,
	output logic [3:0]  pulse1_decay,
	output logic [3:0]  pulse2_decay,
	output logic [3:0]  noise_decay,
	output logic [6:0]  linear_level,
	output logic [3:0]  length_active
);
	import afs_pkg::*;

	logic       take, tick, wr;
	frame_evt_t evt, ev;
	logic       wrap4;

	logic [1:0]  mode_q;
	logic        irq_q;
	logic [7:0]  vol_q [3];
	logic [7:0]  swp_q [2];
	logic [7:0]  tri_q;
	logic [3:0]  en_q;
	logic [10:0] per_q [2];
	logic [2:0]  est_q;
	logic [3:0]  ediv_q [3];
	logic [3:0]  edec_q [3];
	logic [6:0]  lin_q;
	logic        lrl_q;
	logic [7:0]  len_q [4];
	logic [2:0]  sdiv_q [2];
	logic [1:0]  srl_q;

	logic [1:0]  mode_d;
	logic        irq_d;
	logic [7:0]  vol_d [3];
	logic [7:0]  swp_d [2];
	logic [7:0]  tri_d;
	logic [3:0]  en_d;
	logic [10:0] per_d [2];
	logic [2:0]  est_d;
	logic [3:0]  ediv_d [3];
	logic [3:0]  edec_d [3];
	logic [6:0]  lin_d;
	logic        lrl_d;
	logic [7:0]  len_d [4];
	logic [2:0]  sdiv_d [2];
	logic [1:0]  srl_d;
	logic [1:0]  mute_d;
	logic [3:0]  act_d;
	logic [11:0] tgt [2];
	logic [11:0] tgt_d [2];

	assign in_stall = out_valid && out_stall;
	assign take = in_valid && !in_stall;
	assign tick = take && !req_type;
	assign wr   = take && req_type;
	assign ev.quarter = tick && evt.quarter;
	assign ev.half    = tick && evt.half;

	afs_timer u_timer (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick),
		.five  (mode_q[1]),
		.evt   (evt),
		.wrap4 (wrap4)
	);

	always_comb begin
		mode_d = mode_q; irq_d = irq_q; tri_d = tri_q; en_d = en_q;
		est_d = est_q; lin_d = lin_q; lrl_d = lrl_q; srl_d = srl_q;
		vol_d = vol_q; swp_d = swp_q; per_d = per_q; ediv_d = ediv_q;
		edec_d = edec_q; len_d = len_q; sdiv_d = sdiv_q;
		for (int i = 0; i < 2; i++)
			tgt[i] = sweep_target(per_q[i], swp_q[i], (i == 0));
		if (wr) begin
			case (reg_addr)
				A_VOL0: vol_d[0] = write_data;
				A_VOL1: vol_d[1] = write_data;
				A_VOL2: vol_d[2] = write_data;
				A_SWP0: begin swp_d[0] = write_data; srl_d[0] = 1'b1; end
				A_SWP1: begin swp_d[1] = write_data; srl_d[1] = 1'b1; end
				A_LO0: per_d[0][7:0] = write_data;
				A_LO1: per_d[1][7:0] = write_data;
				A_HI0: begin
					per_d[0][10:8] = write_data[2:0];
					if (en_q[0]) len_d[0] = len_lookup(write_data[7:3]);
					est_d[0] = 1'b1;
				end
				A_HI1: begin
					per_d[1][10:8] = write_data[2:0];
					if (en_q[1]) len_d[1] = len_lookup(write_data[7:3]);
					est_d[1] = 1'b1;
				end
				A_TRI: tri_d = write_data;
				A_TRILEN: begin
					if (en_q[2]) len_d[2] = len_lookup(write_data[7:3]);
					lrl_d = 1'b1;
				end
				A_NOILEN: begin
					if (en_q[3]) len_d[3] = len_lookup(write_data[7:3]);
					est_d[2] = 1'b1;
				end
				A_ENABLE: begin
					en_d = write_data[3:0];
					for (int c = 0; c < 4; c++)
						if (!write_data[c]) len_d[c] = 8'd0;
				end
				A_FRAME: begin
					mode_d = write_data[7:6];
					if (write_data[6]) irq_d = 1'b0;
				end
				default: ;
			endcase
		end
		if (ev.quarter) begin
			for (int i = 0; i < 3; i++) begin
				if (est_q[i]) begin
					est_d[i] = 1'b0;
					edec_d[i] = 4'd15;
					ediv_d[i] = vol_q[i][3:0];
				end else if (ediv_q[i] == 4'd0) begin
					ediv_d[i] = vol_q[i][3:0];
					if (edec_q[i] != 4'd0) edec_d[i] = edec_q[i] - 4'd1;
					else if (vol_q[i][5]) edec_d[i] = 4'd15;
				end else begin
					ediv_d[i] = ediv_q[i] - 4'd1;
				end
			end
			if (lrl_q) lin_d = tri_q[6:0];
			else if (lin_q != 7'd0) lin_d = lin_q - 7'd1;
			if (!tri_q[7]) lrl_d = 1'b0;
		end
		if (ev.half) begin
			for (int c = 0; c < 4; c++) begin
				if (!en_q[c]) len_d[c] = 8'd0;
				else if (len_q[c] != 8'd0 &&
					!((c == 2) ? tri_q[7] : (c == 3) ? vol_q[2][5] : vol_q[c][5]))
					len_d[c] = len_q[c] - 8'd1;
			end
			for (int i = 0; i < 2; i++) begin
				if (sdiv_q[i] == 3'd0 && swp_q[i][7] && swp_q[i][2:0] != 3'd0 &&
					!(per_q[i] < 11'd8 || tgt[i] > PERIOD_MAX))
					per_d[i] = tgt[i][10:0];
				if (sdiv_q[i] == 3'd0 || srl_q[i]) begin
					sdiv_d[i] = swp_q[i][6:4];
					srl_d[i] = 1'b0;
				end else begin
					sdiv_d[i] = sdiv_q[i] - 3'd1;
				end
			end
		end
		if (tick && wrap4 && !mode_q[1] && !mode_q[0]) irq_d = 1'b1;
		for (int i = 0; i < 2; i++) begin
			tgt_d[i] = sweep_target(per_d[i], swp_d[i], (i == 0));
			mute_d[i] = (per_d[i] < 11'd8) || (tgt_d[i] > PERIOD_MAX);
		end
		for (int c = 0; c < 4; c++)
			act_d[c] = (len_d[c] != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; irq_q <= 1'b0; tri_q <= '0; en_q <= '0; est_q <= '0;
			lin_q <= '0; lrl_q <= 1'b0; srl_q <= '0;
			for (int i = 0; i < 3; i++) begin
				vol_q[i] <= '0; ediv_q[i] <= '0; edec_q[i] <= '0;
			end
			for (int i = 0; i < 2; i++) begin
				swp_q[i] <= '0; per_q[i] <= '0; sdiv_q[i] <= '0;
			end
			for (int c = 0; c < 4; c++) len_q[c] <= '0;
		end else if (take) begin
			mode_q <= mode_d; irq_q <= irq_d; tri_q <= tri_d; en_q <= en_d;
			est_q <= est_d; lin_q <= lin_d; lrl_q <= lrl_d; srl_q <= srl_d;
			vol_q <= vol_d; swp_q <= swp_d; per_q <= per_d; ediv_q <= ediv_d;
			edec_q <= edec_d; len_q <= len_d; sdiv_q <= sdiv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (!in_stall) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_irq     <= irq_d;
			quarter_frame <= ev.quarter;
			half_frame    <= ev.half;
			pulse1_period <= per_d[0];
			pulse2_period <= per_d[1];
			sweep_mute    <= mute_d;
			pulse1_decay  <= edec_d[0];
			pulse2_decay  <= edec_d[1];
			noise_decay   <= edec_d[2];
			linear_level  <= lin_d;
			length_active <= act_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("taken word produced no status word");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && req_type) |=> !quarter_frame && !half_frame)
		else $error("frame event on a register write");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && !req_type && mode_q[1]) |=> frame_irq == $past(irq_q))
		else $error("irq raised in five step mode");

endmodule

/* dv/apu_frame_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apu_frame_sequencer_tb: self-checking bench for the frame sequencer
// Drives ticks and register writes with random gaps and random output stalls.
// An internal model of the envelopes, sweeps, linear and length counters and
// the two frame counters predicts one status word per input word. Every status
// word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module apu_frame_sequencer_tb;
	import afs_pkg::*;

	typedef struct {
		logic        wr;
		logic [4:0]  addr;
		logic [7:0]  data;
		logic        drain;
	} apu_word_t;

	typedef struct {
		logic        irq;
		logic        qf;
		logic        hf;
		logic [10:0] p1;
		logic [10:0] p2;
		logic [1:0]  mute;
		logic [3:0]  d1;
		logic [3:0]  d2;
		logic [3:0]  dn;
		logic [6:0]  lin;
		logic [3:0]  act;
	} apu_status_t;

	localparam int RANDOM_WORDS = 1424;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = 1'b0;
	logic [4:0]  reg_addr = '0;
	logic [7:0]  write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        frame_irq, quarter_frame, half_frame;
	logic [10:0] pulse1_period, pulse2_period;
	logic [1:0]  sweep_mute;
	logic [3:0]  pulse1_decay, pulse2_decay, noise_decay;
	logic [6:0]  linear_level;
	logic [3:0]  length_active;

	apu_word_t   words_pending[$];
	apu_status_t status_due[$];
	int          fails = 0;
	bit          took = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          stalling = 0;

	// model state
	int          cnt4, cnt5;
	logic [1:0]  mode;
	logic        irq;
	logic [7:0]  vol[3];
	logic [7:0]  swp[2];
	logic [7:0]  tri_ctl;
	logic [3:0]  en;
	logic [10:0] per[2];
	logic        est[3];
	logic [3:0]  ediv[3];
	logic [3:0]  edec[3];
	logic [6:0]  lin;
	logic        lin_rel;
	logic [7:0]  lens[4];
	logic [2:0]  sdiv[2];
	logic        srel[2];

	const logic [7:0] length_loads[32] = '{
		10, 254, 20, 2, 40, 4, 80, 6, 160, 8, 60, 10, 14, 12, 26, 14,
		12, 16, 24, 18, 48, 20, 96, 22, 192, 24, 72, 26, 16, 28, 32, 30};

	always #5 clk = ~clk;

	apu_frame_sequencer i_dut (.*);

	function automatic int sweep_goal(int i);
		int p, d, t;
		p = per[i];
		d = p >> swp[i][2:0];
		if (swp[i][3]) t = p - d - (i == 0 ? 1 : 0);
		else t = p + d;
		if (t < 0) t = 0;
		return t;
	endfunction

	function automatic bit sweep_silenced(int i);
		return per[i] < 8 || sweep_goal(i) > 2047;
	endfunction

	function automatic void load_length(int ch, logic [7:0] d);
		if (en[ch]) lens[ch] = length_loads[d[7:3]];
	endfunction

	function automatic void clear_model();
		cnt4 = 0; cnt5 = 0; mode = '0; irq = 0; tri_ctl = '0; en = '0;
		lin = '0; lin_rel = 0;
		for (int i = 0; i < 3; i++) begin
			vol[i] = '0; est[i] = 0; ediv[i] = '0; edec[i] = '0;
		end
		for (int i = 0; i < 2; i++) begin
			swp[i] = '0; per[i] = '0; sdiv[i] = '0; srel[i] = 0;
		end
		for (int i = 0; i < 4; i++) lens[i] = '0;
	endfunction

	function automatic apu_status_t apu_step(apu_word_t w);
		apu_status_t s;
		bit five, qf, hf, halt;
		int pos;
		qf = 0; hf = 0;
		if (w.wr) begin
			case (w.addr)
				A_VOL0: vol[0] = w.data;
				A_VOL1: vol[1] = w.data;
				A_VOL2: vol[2] = w.data;
				A_SWP0, A_SWP1: begin
					swp[w.addr == A_SWP1] = w.data;
					srel[w.addr == A_SWP1] = 1;
				end
				A_LO0, A_LO1: per[w.addr == A_LO1][7:0] = w.data;
				A_HI0, A_HI1: begin
					per[w.addr == A_HI1][10:8] = w.data[2:0];
					load_length(w.addr == A_HI1, w.data);
					est[w.addr == A_HI1] = 1;
				end
				A_TRI: tri_ctl = w.data;
				A_TRILEN: begin
					load_length(2, w.data);
					lin_rel = 1;
				end
				A_NOILEN: begin
					load_length(3, w.data);
					est[2] = 1;
				end
				A_ENABLE: begin
					en = w.data[3:0];
					for (int c = 0; c < 4; c++) if (!en[c]) lens[c] = '0;
				end
				A_FRAME: begin
					mode = w.data[7:6];
					if (w.data[6]) irq = 0;
				end
				default: ;
			endcase
		end else begin
			five = mode[1];
			pos = five ? cnt5 : cnt4;
			if (pos == STEP_ONE || pos == STEP_THREE) qf = 1;
			else if (pos == STEP_TWO || pos == 0) begin
				qf = 1; hf = 1;
			end
			if (qf) begin
				for (int i = 0; i < 3; i++) begin
					if (est[i]) begin
						est[i] = 0; edec[i] = 15; ediv[i] = vol[i][3:0];
					end else if (ediv[i] == 0) begin
						ediv[i] = vol[i][3:0];
						if (edec[i] != 0) edec[i]--;
						else if (vol[i][5]) edec[i] = 15;
					end else ediv[i]--;
				end
				if (lin_rel) lin = tri_ctl[6:0];
				else if (lin != 0) lin--;
				if (!tri_ctl[7]) lin_rel = 0;
			end
			if (hf) begin
				for (int c = 0; c < 4; c++) begin
					halt = (c == 2) ? tri_ctl[7] : (c == 3) ? vol[2][5] : vol[c][5];
					if (!en[c]) lens[c] = '0;
					else if (lens[c] != 0 && !halt) lens[c]--;
				end
				for (int i = 0; i < 2; i++) begin
					if (sdiv[i] == 0 && swp[i][7] && swp[i][2:0] != 0 && !sweep_silenced(i))
						per[i] = 11'(sweep_goal(i));
					if (sdiv[i] == 0 || srel[i]) begin
						sdiv[i] = swp[i][6:4]; srel[i] = 0;
					end else sdiv[i]--;
				end
			end
			if (pos == 0 && !five && !mode[0]) irq = 1;
			cnt4 = (cnt4 + 1 >= FOUR_STEP_LEN) ? 0 : cnt4 + 1;
			cnt5 = (cnt5 + 1 >= FIVE_STEP_LEN) ? 0 : cnt5 + 1;
		end
		s.irq = irq; s.qf = qf; s.hf = hf; s.p1 = per[0]; s.p2 = per[1];
		s.mute = {sweep_silenced(1), sweep_silenced(0)};
		s.d1 = edec[0]; s.d2 = edec[1]; s.dn = edec[2]; s.lin = lin;
		for (int c = 0; c < 4; c++) s.act[c] = lens[c] != 0;
		return s;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	task automatic add_write(logic [4:0] a, logic [7:0] d);
		words_pending.push_back('{1'b1, a, d, 1'b0});
	endtask

	task automatic add_tick();
		words_pending.push_back('{1'b0, 5'($urandom), 8'($urandom), 1'b0});
	endtask

	// check status words, then record the word taken at this edge
	always @(posedge clk) begin
		apu_status_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (status_due.size() == 0) begin
				$error("status word with none expected");
				fails++;
			end else begin
				e = status_due.pop_front();
				check_field("frame_irq", e.irq, frame_irq);
				check_field("quarter_frame", e.qf, quarter_frame);
				check_field("half_frame", e.hf, half_frame);
				check_field("pulse1_period", e.p1, pulse1_period);
				check_field("pulse2_period", e.p2, pulse2_period);
				check_field("sweep_mute", e.mute, sweep_mute);
				check_field("pulse1_decay", e.d1, pulse1_decay);
				check_field("pulse2_decay", e.d2, pulse2_decay);
				check_field("noise_decay", e.dn, noise_decay);
				check_field("linear_level", e.lin, linear_level);
				check_field("length_active", e.act, length_active);
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			status_due.push_back(apu_step('{req_type, reg_addr, write_data, 1'b0}));
			took = 1;
		end
	end

	// word driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			took = 0;
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (words_pending.size() > 0 &&
					!(words_pending[0].drain && status_due.size() > 0)) begin
				in_valid <= 1'b1;
				req_type <= words_pending[0].wr;
				reg_addr <= words_pending[0].addr;
				write_data <= words_pending[0].data;
				void'(words_pending.pop_front());
				gap_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls: runs of stalls and runs of free cycles
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stalling = ($urandom_range(3) == 0) ? !stalling : 1'b0;
			stall_left = stalling ? pick_gap() + 1 : $urandom_range(60, 1);
		end
		stall_left--;
		out_stall <= stalling;
	end

	initial begin
		logic [4:0] used_addr[14];
		logic [4:0] a;
		logic [7:0] d;
		used_addr = '{A_VOL0, A_SWP0, A_LO0, A_HI0, A_VOL1, A_SWP1, A_LO1, A_HI1,
			A_TRI, A_TRILEN, A_VOL2, A_NOILEN, A_ENABLE, A_FRAME};
		clear_model();

		// directed: every register, table extremes, unused offsets, mode flips
		add_write(A_ENABLE, 8'h0f);
		add_write(A_VOL0, 8'h05);
		add_write(A_VOL1, 8'h20);
		add_write(A_VOL2, 8'h3f);
		add_write(A_SWP0, 8'h89);
		add_write(A_SWP1, 8'hf9);
		add_write(A_LO0, 8'h00);
		add_write(A_HI0, 8'hf8);
		add_write(A_LO1, 8'hff);
		add_write(A_HI1, 8'h07);
		add_write(A_TRI, 8'hff);
		add_write(A_TRILEN, 8'h08);
		add_write(A_NOILEN, 8'hff);
		add_write(5'h09, 8'haa);
		add_write(5'h10, 8'h55);
		add_write(5'h16, 8'hff);
		add_write(5'h1f, 8'hff);
		add_write(A_FRAME, 8'h00);
		add_tick();
		add_tick();
		add_write(A_ENABLE, 8'h00);
		add_write(A_ENABLE, 8'h0f);
		add_write(A_FRAME, 8'hc0);
		add_tick();
		add_write(A_FRAME, 8'h40);
		add_tick();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 500 == 499) begin
				add_tick();
				words_pending[$].drain = 1'b1;
			end else if ($urandom_range(39) != 0) begin
				add_tick();
			end else begin
				a = ($urandom_range(9) < 7) ? used_addr[$urandom_range(13)] : 5'($urandom);
				d = 8'($urandom);
				if (a == A_FRAME) begin
					if ($urandom_range(199) != 0) a = A_LO0;
					else d[7:6] = ($urandom_range(3) == 0) ? 2'($urandom) : {d[7], 1'b0};
				end else if (a == A_ENABLE && $urandom_range(3) != 0) begin
					d[3:0] = 4'hf;
				end
				add_write(a, d);
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (words_pending.size() == 0 && !in_valid);
		for (int c = 0; c < 2000 && status_due.size() > 0; c++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (status_due.size() > 0) begin
			$error("%0d status words never arrived", status_due.size());
			fails++;
		end
		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
sv/afs_pkg.sv
sv/afs_timer.sv
sv/apu_frame_sequencer.sv
dv/apu_frame_sequencer_tb.sv
